>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// check prop at every rising edge of clk, disabled while rst is high
`define ASSERT_PROP_DR(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check prop at every rising edge of clk
`define ASSERT_PROP(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_PROP_DR(label, clk, rst, prop, msg)

`define ASSERT_PROP(label, clk, prop, msg)

`endif

`endif

>>> design/wis_pkg.sv
// ----------------------------------------------------------------------------
// wis_pkg
// Shared widths, controller states and command/status bundles for the
// weighted interval scheduling core.
// ----------------------------------------------------------------------------
package wis_pkg;

   localparam int MAX_JOBS_DEFAULT = 256;

   localparam int TIME_W   = 16;
   localparam int WEIGHT_W = 16;
   localparam int PROFIT_W = 24;
   localparam int ENTRY_W  = TIME_W + PROFIT_W;

   localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STORE,
      ST_EMIT
   } wis_state_type;

   typedef struct packed {
      logic capture;       // latch the incoming job
      logic drop;          // set full: flag overflow, keep the job out
      logic clear_earlier; // no compatible job: earlier profit is zero
      logic scan_start;    // read the most recent stored job
      logic scan_step;     // read one job further back
      logic take_hit;      // compatible job found: keep its profit
      logic store;         // write finish time and best profit, bump count
      logic emit;          // load the result register, clear the set
   } wis_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic in_last;       // last flag on the input port
      logic last;          // last flag of the captured job
      logic hit;           // read finish time fits before captured start
      logic ptr_zero;      // scan reached the first stored job
   } wis_status_type;

endpackage

>>> design/weighted_interval_scheduling_core.sv
// ----------------------------------------------------------------------------
// weighted_interval_scheduling_core
// Weighted interval scheduling by dynamic programming, one job per
// transaction, jobs sorted by finish time; one result per set.
// ----------------------------------------------------------------------------
//   channel  handshake             payload
//   req      req_valid/req_stall   start_time, finish_time, job_weight, last_job
//   rsp      rsp_valid/rsp_stall   best_profit, overflow
//
// A job scans back over k stored jobs (1..MAX_JOBS-1) until one fits or none
// is left; the first job of a set and a job dropped from a full store skip it.
// The single read port of the job store compares one finish time per cycle.
// A last job then passes through an emit state that loads the result.
// Reset clears the controller, job count and overflow flag; the store needs
// no clearing pass. A waiting result does not block new jobs; only a second
// result that finds the result register still stalled holds the block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module weighted_interval_scheduling_core
   import wis_pkg::*;
#(
   parameter int MAX_JOBS = MAX_JOBS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [TIME_W-1:0]   req_start_time,
   input  logic [TIME_W-1:0]   req_finish_time,
   input  logic [WEIGHT_W-1:0] req_job_weight,
   input  logic                req_last_job,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PROFIT_W-1:0] rsp_best_profit,
   output logic                rsp_overflow
);

   wis_cmd_type    cmd;
   wis_status_type status;

   wis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wis_datapath #(
      .MAX_JOBS (MAX_JOBS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_start_time  (req_start_time),
      .req_finish_time (req_finish_time),
      .req_job_weight  (req_job_weight),
      .req_last_job    (req_last_job),
      .rsp_best_profit (rsp_best_profit),
      .rsp_overflow    (rsp_overflow)
   );

   `ASSERT_PROP_DR(a_store_not_full, clock, reset, cmd.store |-> !status.count_full, "store into a full job table")
   `ASSERT_PROP_DR(a_store_no_scan, clock, reset, cmd.store |-> !(cmd.scan_start || cmd.scan_step), "store overlaps a scan read")
   `ASSERT_PROP_DR(a_emit_clears, clock, reset, cmd.emit |=> (status.count_zero && rsp_valid), "set not cleared after result")
   `ASSERT_PROP_DR(a_full_drops, clock, reset, (req_valid && !req_stall && status.count_full) |-> cmd.drop, "job accepted into full table")

endmodule

>>> design/wis_ram.sv
// ----------------------------------------------------------------------------
// wis_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module wis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/wis_datapath.sv
// ----------------------------------------------------------------------------
// wis_datapath
// Job registers, job store, backward scan pointer, profit arithmetic and
// result register.
// ----------------------------------------------------------------------------
module wis_datapath
   import wis_pkg::*;
#(
   parameter int MAX_JOBS = MAX_JOBS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  wis_cmd_type         cmd,
   output wis_status_type      status,
   input  logic [TIME_W-1:0]   req_start_time,
   input  logic [TIME_W-1:0]   req_finish_time,
   input  logic [WEIGHT_W-1:0] req_job_weight,
   input  logic                req_last_job,
   output logic [PROFIT_W-1:0] rsp_best_profit,
   output logic                rsp_overflow
);

   localparam int AW = $clog2(MAX_JOBS);
   localparam int CW = $clog2(MAX_JOBS + 1);

   logic [TIME_W-1:0]   start_ff;
   logic [TIME_W-1:0]   finish_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic                last_ff;
   logic [PROFIT_W-1:0] earlier_ff, earlier_in;
   logic [PROFIT_W-1:0] best_ff, best_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                overflow_ff, overflow_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [PROFIT_W-1:0] rsp_best_ff;
   logic                rsp_overflow_ff;

   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [ENTRY_W-1:0]  rd_data;
   logic [TIME_W-1:0]   rd_finish;
   logic [PROFIT_W-1:0] rd_profit;
   logic [PROFIT_W:0]   take_sum;
   logic [PROFIT_W-1:0] take;
   logic [PROFIT_W-1:0] new_best;
   logic [ENTRY_W-1:0]  wr_data;

   wis_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_JOBS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_finish = rd_data[ENTRY_W-1:PROFIT_W];
   assign rd_profit = rd_data[PROFIT_W-1:0];

   always_comb begin
      rd_en   = cmd.scan_start | cmd.scan_step;
      rd_addr = cmd.scan_start ? AW'(count_ff - CW'(1)) : ptr_ff - AW'(1);
      ptr_in  = rd_en ? rd_addr : ptr_ff;
   end

   always_comb begin
      take_sum = {1'b0, earlier_ff} + (PROFIT_W + 1)'(weight_ff);
      take     = take_sum[PROFIT_W] ? PROFIT_MAX : take_sum[PROFIT_W-1:0];
      new_best = (take > best_ff) ? take : best_ff;
      wr_data  = {finish_ff, new_best};
   end

   always_comb begin
      earlier_in = earlier_ff;
      if (cmd.clear_earlier) begin
         earlier_in = '0;
      end else if (cmd.take_hit) begin
         earlier_in = rd_profit;
      end
   end

   always_comb begin
      best_in     = best_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.emit) begin
         best_in     = '0;
         count_in    = '0;
         overflow_in = 1'b0;
      end else begin
         if (cmd.store) begin
            best_in  = new_best;
            count_in = count_ff + CW'(1);
         end
         if (cmd.drop) begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff     <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         best_ff     <= best_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         start_ff  <= req_start_time;
         finish_ff <= req_finish_time;
         weight_ff <= req_job_weight;
         last_ff   <= req_last_job;
      end
      if (cmd.emit) begin
         rsp_best_ff     <= best_ff;
         rsp_overflow_ff <= overflow_ff;
      end
      earlier_ff <= earlier_in;
      ptr_ff     <= ptr_in;
   end

   always_comb begin
      status.count_zero = (count_ff == '0);
      status.count_full = (count_ff == CW'(MAX_JOBS));
      status.in_last    = req_last_job;
      status.last       = last_ff;
      status.hit        = (rd_finish <= start_ff);
      status.ptr_zero   = (ptr_ff == '0);
   end

   assign rsp_best_profit = rsp_best_ff;
   assign rsp_overflow    = rsp_overflow_ff;

endmodule

>>> design/wis_ctrl.sv
// ----------------------------------------------------------------------------
// wis_ctrl
// Controller: accepts jobs, steps the backward scan one stored job per
// cycle, stores the result and hands the set total to the result register.
// ----------------------------------------------------------------------------
module wis_ctrl
   import wis_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  wis_status_type status,
   output wis_cmd_type    cmd
);

   wis_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.count_full) begin
                  state_in = status.in_last ? ST_EMIT : ST_IDLE;
               end else if (status.count_zero) begin
                  state_in = ST_STORE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.hit || status.ptr_zero) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            state_in = status.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               priority if (status.count_full) begin
                  cmd.drop = 1'b1;
               end else if (status.count_zero) begin
                  cmd.clear_earlier = 1'b1;
               end else begin
                  cmd.scan_start = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            priority if (status.hit) begin
               cmd.take_hit = 1'b1;
            end else if (status.ptr_zero) begin
               cmd.clear_earlier = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = slot_free;
         end
         default: cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> tb/tb_weighted_interval_scheduling_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_interval_scheduling_core
// Self-checking bench for the weighted interval scheduling core. A short
// table of directed jobs (single-job sets, overlap, chains, unsorted input,
// a full store with dropped jobs) runs first, then random sets, mostly sorted
// by finish time. A scoring model tracks the stored jobs and predicts each
// set total, and every result is compared field by field. Both sides idle at
// random, and once the result side holds off long enough to back up the
// job input.
// ----------------------------------------------------------------------------
module tb_weighted_interval_scheduling_core;
   import wis_pkg::*;

   localparam int JOB_CAP        = MAX_JOBS_DEFAULT;
   localparam int JOB_AW         = $clog2(JOB_CAP);
   localparam int RESET_CYCLES   = 9;
   localparam int RANDOM_JOBS    = 680;
   localparam int HOLD_CYCLES    = 1500;
   localparam int DRAIN_CYCLES   = 2 * JOB_CAP + 16;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [TIME_W-1:0]   t_start;
      logic [TIME_W-1:0]   t_finish;
      logic [WEIGHT_W-1:0] weight;
      logic                fin_flag;
      logic [8:0]          reps;
      logic                typed;
      logic [PROFIT_W-1:0] profit;
      logic                ovf;
   } job_row_type;

   typedef struct packed {
      logic [PROFIT_W-1:0] profit;
      logic                overflow;
   } set_total_type;

   localparam int NUM_ROWS = 17;
   localparam job_row_type DIRECTED [NUM_ROWS] = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b1, 9'd1,   1'b1, 24'd0,        1'b0},
      '{16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 9'd1,   1'b1, 24'd65535,    1'b0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 9'd1,   1'b1, 24'd65535,    1'b0},
      '{16'd0,    16'd10,   16'd5,    1'b0, 9'd1,   1'b0, 24'd0,        1'b0},
      '{16'd5,    16'd20,   16'd7,    1'b1, 9'd1,   1'b0, 24'd0,        1'b0},
      '{16'd0,    16'd10,   16'd5,    1'b0, 9'd1,   1'b0, 24'd0,        1'b0},
      '{16'd10,   16'd20,   16'd7,    1'b1, 9'd1,   1'b0, 24'd0,        1'b0},
      '{16'd100,  16'd200,  16'd30,   1'b0, 9'd1,   1'b0, 24'd0,        1'b0},
      '{16'd50,   16'd250,  16'd40,   1'b0, 9'd1,   1'b0, 24'd0,        1'b0},
      '{16'd0,    16'd300,  16'd20,   1'b1, 9'd1,   1'b0, 24'd0,        1'b0},
      '{16'd0,    16'd500,  16'd9,    1'b0, 9'd1,   1'b0, 24'd0,        1'b0},
      '{16'd0,    16'd100,  16'd3,    1'b1, 9'd1,   1'b0, 24'd0,        1'b0},
      '{16'h0000, 16'h0000, 16'hFFFF, 1'b0, 9'd256, 1'b0, 24'd0,        1'b0},
      '{16'h0000, 16'h0000, 16'd7,    1'b0, 9'd2,   1'b0, 24'd0,        1'b0},
      '{16'h0000, 16'h0000, 16'd1,    1'b1, 9'd1,   1'b1, 24'd16776960, 1'b1},
      '{16'd1,    16'd1,    16'd1,    1'b1, 9'd1,   1'b1, 24'd1,        1'b0},
      '{16'd5,    16'd9,    16'hFFFF, 1'b1, 9'd2,   1'b0, 24'd0,        1'b0}
   };

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [TIME_W-1:0]   req_start_time  = '0;
   logic [TIME_W-1:0]   req_finish_time = '0;
   logic [WEIGHT_W-1:0] req_job_weight  = '0;
   logic                req_last_job    = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [PROFIT_W-1:0] rsp_best_profit;
   logic                rsp_overflow;

   logic [TIME_W-1:0]   held_finish [JOB_CAP];
   logic [PROFIT_W-1:0] held_best   [JOB_CAP];
   int                  held_jobs   = 0;
   logic                held_over   = 1'b0;

   set_total_type expected_totals [$];

   int  errors        = 0;
   int  jobs_accepted = 0;
   int  jobs_dropped  = 0;
   int  random_jobs   = 0;
   int  sets_checked  = 0;
   int  overflow_sets = 0;
   bit  steady        = 1'b0;
   bit  hold_pending  = 1'b0;

   always #6 clock = ~clock;

   weighted_interval_scheduling_core #(
      .MAX_JOBS(JOB_CAP)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_time (req_start_time),
      .req_finish_time(req_finish_time),
      .req_job_weight (req_job_weight),
      .req_last_job   (req_last_job),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_profit(rsp_best_profit),
      .rsp_overflow   (rsp_overflow)
   );

   function automatic bit schedule_job(input logic [TIME_W-1:0] t_start,
                                       input logic [TIME_W-1:0] t_finish,
                                       input logic [WEIGHT_W-1:0] weight,
                                       input logic fin_flag,
                                       output set_total_type total);
      logic [PROFIT_W-1:0] earlier;
      logic [PROFIT_W-1:0] skip;
      logic [PROFIT_W:0]   take;
      bit                  found;
      int                  j;
      total = '0;
      if (held_jobs < JOB_CAP) begin
         earlier = '0;
         found   = 1'b0;
         for (j = held_jobs - 1; j >= 0 && !found; j--) begin
            if (held_finish[j[JOB_AW-1:0]] <= t_start) begin
               earlier = held_best[j[JOB_AW-1:0]];
               found   = 1'b1;
            end
         end
         take = {1'b0, earlier} + (PROFIT_W + 1)'(weight);
         if (take > {1'b0, PROFIT_MAX}) take = {1'b0, PROFIT_MAX};
         skip = (held_jobs > 0) ? held_best[JOB_AW'(held_jobs - 1)] : '0;
         held_finish[JOB_AW'(held_jobs)] = t_finish;
         held_best[JOB_AW'(held_jobs)]   =
            (take[PROFIT_W-1:0] > skip) ? take[PROFIT_W-1:0] : skip;
         held_jobs++;
      end else begin
         held_over = 1'b1;
         jobs_dropped++;
      end
      if (!fin_flag) return 1'b0;
      total.profit   = (held_jobs > 0) ? held_best[JOB_AW'(held_jobs - 1)] : '0;
      total.overflow = held_over;
      held_jobs = 0;
      held_over = 1'b0;
      return 1'b1;
   endfunction

   task automatic send_job(input logic [TIME_W-1:0] t_start,
                           input logic [TIME_W-1:0] t_finish,
                           input logic [WEIGHT_W-1:0] weight,
                           input logic fin_flag,
                           input logic typed,
                           input logic [PROFIT_W-1:0] typed_profit,
                           input logic typed_ovf);
      set_total_type total;
      while (!steady && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_start_time  <= t_start;
      req_finish_time <= t_finish;
      req_job_weight  <= weight;
      req_last_job    <= fin_flag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      jobs_accepted++;
      if (schedule_job(t_start, t_finish, weight, fin_flag, total)) begin
         if (typed) begin
            total.profit   = typed_profit;
            total.overflow = typed_ovf;
         end
         expected_totals.push_back(total);
      end
   endtask

   task automatic random_set(input int n, input bit sorted);
      int                  fin;
      int                  span;
      int                  len;
      int                  hi;
      logic [TIME_W-1:0]   st;
      logic [TIME_W-1:0]   fin_out;
      logic [WEIGHT_W-1:0] weight;
      case ($urandom_range(0, 2))
         0: span = 3;
         1: span = 60;
         default: span = 2000;
      endcase
      hi  = 65535 - n * span;
      fin = (hi > 0) ? $urandom_range(0, hi) : 0;
      for (int k = 0; k < n; k++) begin
         fin += $urandom_range(0, span);
         if (fin > 65535) fin = 65535;
         len = $urandom_range(0, span * 4);
         st  = (fin > len) ? TIME_W'(fin - len) : '0;
         if ($urandom_range(0, 7) == 0) st = TIME_W'($urandom_range(0, 65535));
         fin_out = TIME_W'(fin);
         if (!sorted) begin
            fin_out = TIME_W'($urandom_range(0, 65535));
            st      = TIME_W'($urandom_range(0, 65535));
         end
         case ($urandom_range(0, 9))
            0: weight = '0;
            1: weight = '1;
            default: weight = WEIGHT_W'($urandom_range(0, 65535));
         endcase
         send_job(st, fin_out, weight, k == n - 1, 1'b0, '0, 1'b0);
         random_jobs++;
      end
   endtask

   task automatic check_total();
      set_total_type want;
      if (expected_totals.size() == 0) begin
         errors++;
         $display("%0t: expected no result, actual best_profit %0d overflow %0b",
                  $time, rsp_best_profit, rsp_overflow);
         return;
      end
      want = expected_totals.pop_front();
      sets_checked++;
      if (want.overflow) overflow_sets++;
      if (rsp_best_profit !== want.profit) begin
         errors++;
         $display("%0t: best_profit expected %0d, actual %0d",
                  $time, want.profit, rsp_best_profit);
      end
      if (rsp_overflow !== want.overflow) begin
         errors++;
         $display("%0t: overflow expected %0b, actual %0b",
                  $time, want.overflow, rsp_overflow);
      end
   endtask

   initial begin : result_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_total();
         if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(0, 99) < 34);
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int          set_idx;
      int          n;
      job_row_type row;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         row = DIRECTED[i];
         for (int r = 0; r < int'(row.reps); r++)
            send_job(row.t_start, row.t_finish, row.weight,
                     row.fin_flag && (r == int'(row.reps) - 1),
                     row.typed, row.profit, row.ovf);
      end

      set_idx = 0;
      while (random_jobs < RANDOM_JOBS) begin
         steady = (set_idx >= 40 && set_idx < 55);
         if (set_idx == 20) begin
            // back up the input behind a stalled result
            hold_pending = 1'b1;
            repeat (16) random_set(1, 1'b1);
         end
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         random_set(n, $urandom_range(0, 4) != 0);
         set_idx++;
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (expected_totals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Scheduled %0d jobs (%0d dropped past capacity) over %0d checked sets,",
               jobs_accepted, jobs_dropped, sets_checked);
      $display("%0d of them flagged overflow; %0d errors.", overflow_sets, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> weighted_interval_scheduling_core.f
+incdir+design
design/wis_pkg.sv
design/wis_ram.sv
design/wis_datapath.sv
design/wis_ctrl.sv
design/weighted_interval_scheduling_core.sv
tb/tb_weighted_interval_scheduling_core.sv
